// ===== sv/slte_pkg.sv =====
// Package: shared constants, opcode and status codes, sequencer state and compare result types.
`timescale 1ns / 1ps
package slte_pkg;

	localparam int CAPACITY = 64;
	localparam int AW       = $clog2(CAPACITY);
	localparam int CW       = $clog2(CAPACITY + 1);
	localparam int DW       = 32;
	localparam int POS_W    = 7;
	localparam int CMPW     = (CW > POS_W) ? CW : POS_W;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_DELETE = 2'd1,
		OP_READ   = 2'd2,
		OP_FIND   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		STS_OK        = 2'd0,
		STS_FULL      = 2'd1,
		STS_NOT_FOUND = 2'd2,
		STS_RANGE     = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_LOAD,
		S_STEP
	} state_t;

	typedef struct packed {
		logic eq;
		logic ge;
	} cmp_res_t;

endpackage

// ===== sv/slte_ram.sv =====
// List store: one write port, one read port with registered read data.
`timescale 1ns / 1ps
module slte_ram (
	input  logic                     clk,
	input  logic                     we,
	input  logic [slte_pkg::AW-1:0]  waddr,
	input  logic [slte_pkg::DW-1:0]  wdata,
	input  logic [slte_pkg::AW-1:0]  raddr,
	output logic [slte_pkg::DW-1:0]  rdata
);
	import slte_pkg::*;

	logic [DW-1:0] mem_q [CAPACITY];
	logic [DW-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== sv/slte_cmp.sv =====
// Shared compare unit: equality and signed greater-or-equal of a stored entry against the key.
`timescale 1ns / 1ps
module slte_cmp (
	input  logic [slte_pkg::DW-1:0]        entry,
	input  logic signed [slte_pkg::DW-1:0] key,
	output slte_pkg::cmp_res_t             res
);
	import slte_pkg::*;

	always_comb begin
		res.eq = (entry == key);
		res.ge = ($signed(entry) >= key);
	end

endmodule

// ===== sv/sorted_list_table_engine_core.sv =====
// Sorted list table engine: request sequencer over the list store and the shared compare unit.
// Full, empty or out-of-range requests complete directly from idle; others go through load, then step,
// walking entries (read one, find/delete up to count); a head insert loads and steps again.
// Throughput: one transaction at a time, one entry per cycle; accepted while busy is low.
// Reset: entry count cleared, sequencer idle, no strobe; store undefined until written.
// The receiver cannot stall: done is high for exactly one cycle per transaction.
`timescale 1ns / 1ps
module sorted_list_table_engine_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [1:0]                     opcode,
	input  logic signed [slte_pkg::DW-1:0] value,
	input  logic [slte_pkg::POS_W-1:0]     position,
	output logic                           done,
	output logic [1:0]                     status,
	output logic signed [slte_pkg::DW-1:0] data,
	output logic [slte_pkg::POS_W-1:0]     found_position,
	output logic [slte_pkg::POS_W-1:0]     entry_count_out
);
	import slte_pkg::*;

	state_t                state_q, state_d;
	logic [AW-1:0]         idx_q, idx_d;
	logic                  found_q, found_d;
	logic [CW-1:0]         count_q, count_d;
	op_t                   op_q, op_d;
	logic signed [DW-1:0]  value_q, value_d;
	logic                  done_q, done_d;
	status_t               status_q, status_d;
	logic signed [DW-1:0]  data_q, data_d;
	logic [POS_W-1:0]      fpos_q, fpos_d;

	logic                  ram_we;
	logic [AW-1:0]         ram_waddr;
	logic [DW-1:0]         ram_wdata;
	logic [AW-1:0]         ram_raddr;
	logic [DW-1:0]         ram_rdata;
	cmp_res_t              cmp;
	logic                  idx_last;
	logic                  pos_bad;

	slte_ram u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	slte_cmp u_cmp (
		.entry (ram_rdata),
		.key   (value_q),
		.res   (cmp)
	);

	assign idx_last = ((CW'(idx_q) + CW'(1)) == count_q);
	assign pos_bad  = (position == POS_W'(0)) || (CMPW'(position) > CMPW'(count_q));

	always_comb begin
		state_d   = state_q;
		idx_d     = idx_q;
		found_d   = found_q;
		count_d   = count_q;
		op_d      = op_q;
		value_d   = value_q;
		done_d    = 1'b0;
		status_d  = status_q;
		data_d    = data_q;
		fpos_d    = fpos_q;
		ram_we    = 1'b0;
		ram_waddr = idx_q;
		ram_wdata = value_q;
		ram_raddr = idx_q;

		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					op_d     = op_t'(opcode);
					value_d  = value;
					found_d  = 1'b0;
					idx_d    = '0;
					data_d   = '0;
					fpos_d   = '0;
					status_d = STS_OK;
					unique case (op_t'(opcode))
						OP_INSERT: begin
							if (CMPW'(count_q) >= CMPW'(CAPACITY)) begin
								status_d = STS_FULL;
								done_d   = 1'b1;
							end else if (count_q == CW'(0)) begin
								ram_we    = 1'b1;
								ram_waddr = '0;
								ram_wdata = value;
								count_d   = count_q + CW'(1);
								done_d    = 1'b1;
							end else begin
								idx_d   = AW'(count_q - CW'(1));
								state_d = S_LOAD;
							end
						end
						OP_READ: begin
							if (pos_bad) begin
								status_d = STS_RANGE;
								done_d   = 1'b1;
							end else begin
								idx_d   = AW'(position - POS_W'(1));
								state_d = S_LOAD;
							end
						end
						OP_DELETE, OP_FIND: begin
							if (count_q == CW'(0)) begin
								status_d = STS_NOT_FOUND;
								done_d   = 1'b1;
							end else begin
								state_d = S_LOAD;
							end
						end
						default: begin
							state_d = S_IDLE;
						end
					endcase
				end
			end
			S_LOAD: begin
				state_d = S_STEP;
			end
			S_STEP: begin
				unique case (op_q)
					OP_INSERT: begin
						ram_we = 1'b1;
						ram_waddr = idx_q + AW'(1);
						if (cmp.ge) begin
							ram_wdata = ram_rdata;
							if (idx_q == AW'(0)) begin
								state_d = S_LOAD;
								op_d    = OP_INSERT;
								found_d = 1'b1;
							end else begin
								ram_raddr = idx_q - AW'(1);
								idx_d     = idx_q - AW'(1);
							end
						end else begin
							ram_wdata = value_q;
							count_d   = count_q + CW'(1);
							done_d    = 1'b1;
							state_d   = S_IDLE;
						end
						if (found_q) begin
							ram_waddr = '0;
							ram_wdata = value_q;
							count_d   = count_q + CW'(1);
							done_d    = 1'b1;
							state_d   = S_IDLE;
						end
					end
					OP_DELETE: begin
						if (found_q) begin
							ram_we    = 1'b1;
							ram_waddr = idx_q - AW'(1);
							ram_wdata = ram_rdata;
						end else if (cmp.eq) begin
							found_d = 1'b1;
						end
						if (idx_last) begin
							done_d  = 1'b1;
							state_d = S_IDLE;
							if (found_q || cmp.eq) begin
								count_d = count_q - CW'(1);
							end else begin
								status_d = STS_NOT_FOUND;
							end
						end else begin
							ram_raddr = idx_q + AW'(1);
							idx_d     = idx_q + AW'(1);
						end
					end
					OP_READ: begin
						data_d  = ram_rdata;
						done_d  = 1'b1;
						state_d = S_IDLE;
					end
					OP_FIND: begin
						if (cmp.eq) begin
							data_d  = ram_rdata;
							fpos_d  = POS_W'(CW'(idx_q) + CW'(1));
							done_d  = 1'b1;
							state_d = S_IDLE;
						end else if (idx_last) begin
							status_d = STS_NOT_FOUND;
							done_d   = 1'b1;
							state_d  = S_IDLE;
						end else begin
							ram_raddr = idx_q + AW'(1);
							idx_d     = idx_q + AW'(1);
						end
					end
					default: begin
						state_d = S_IDLE;
					end
				endcase
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			done_q  <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		idx_q    <= idx_d;
		found_q  <= found_d;
		op_q     <= op_d;
		value_q  <= value_d;
		status_q <= status_d;
		data_q   <= data_d;
		fpos_q   <= fpos_d;
	end

	assign busy            = (state_q != S_IDLE);
	assign done            = done_q;
	assign status          = status_q;
	assign data            = data_q;
	assign found_position  = fpos_q;
	assign entry_count_out = POS_W'(count_q);

`ifndef ASSERT_OFF
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while sequencer busy");

	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy || done))
		else $error("accepted transaction neither started nor finished");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		CMPW'(count_q) <= CMPW'(CAPACITY))
		else $error("entry count above capacity");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == STS_FULL) |-> (CMPW'(count_q) == CMPW'(CAPACITY)))
		else $error("store full reported below capacity");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status == STS_NOT_FOUND || status == STS_RANGE))
			|-> (data == '0 && found_position == '0))
		else $error("miss result carries data");
`endif

endmodule
